// ----- src/ctf_pkg.sv -----
// ============================================================================
// ctf_pkg
// Shared types, constants and the arctangent table of the tilt filter.
// ============================================================================
package ctf_pkg;

    // Angle range in 1/256 degree and one full turn.
    localparam int ANG_LIMIT  = 46080;
    localparam int ANG_SPAN   = 92160;

    // Gyro path weight of one in Q10.
    localparam int WEIGHT_ONE = 1024;

    // Gyro increment: (rate * ms * 64 + GYRO_ROUND) / GYRO_DIV.
    localparam int GYRO_DIV   = 32750;
    localparam int GYRO_ROUND = 16375;

    // Yaw wrap: a bias of half a turn plus whole turns keeps the sum positive before reduction.
    localparam int YAW_WRAP_STEPS = 8;
    localparam int YAW_BIAS       = ANG_LIMIT + ANG_SPAN * 128;

    // Iteration counts of the serial units.
    localparam int ROOT_STEPS  = 24;
    localparam int MUL_STEPS   = 16;
    localparam int DIV_STEPS   = 25;
    localparam int BLEND_STEPS = 11;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_GYRO_WEIGHT   = 3'd0,
        CFG_ROLL_TRIM     = 3'd1,
        CFG_PITCH_TRIM    = 3'd2,
        CFG_GYRO_OFFSET_X = 3'd3,
        CFG_GYRO_OFFSET_Y = 3'd4,
        CFG_GYRO_OFFSET_Z = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {S_IDLE, S_FRONT, S_BACK, S_DONE} t_top_state;
    typedef enum logic [1:0] {T_IDLE, T_SQB, T_ROOT, T_ROT} t_tilt_state;
    typedef enum logic [1:0] {G_IDLE, G_MUL, G_LOAD, G_DIV} t_gyro_state;
    typedef enum logic [1:0] {B_IDLE, B_MAC, B_FIN} t_blend_state;

    // atan(2^-i) in 1/65536 degree.
    function automatic logic signed [24:0] atan_step(input logic [4:0] idx);
        logic signed [24:0] v;
        case (idx)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            5'd20:   v = 25'sd4;
            5'd21:   v = 25'sd2;
            5'd22:   v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/ctf_if.sv -----
// ============================================================================
// ctf_if
// Valid/ready channels of the tilt filter: IMU sample in, angles out.
// ============================================================================
interface ctf_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic        [15:0] elapsed_ms;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    elapsed_ms, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  elapsed_ms, output ready);
endinterface

interface ctf_result_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] roll_out;
    logic signed [16:0] pitch_out;
    logic signed [16:0] yaw_out;

    modport source (output valid, roll_out, pitch_out, yaw_out, input ready);
    modport sink (input valid, roll_out, pitch_out, yaw_out, output ready);
endinterface

// ----- src/imu_complementary_tilt_filter.sv -----
// ============================================================================
// imu_complementary_tilt_filter
// Roll / pitch complementary filter and yaw integrator for one IMU sample
// per beat, built from bit-serial square root, CORDIC, divider and MAC units.
// ============================================================================
// The square root plus CORDIC pass and the serial gyro divider run in
// parallel. A sample is accepted only after the previous result is
// loaded; the next sample is taken while the previous result beat
// still waits on the output.
// Reset: synchronous; angles clear to zero, registers take their defaults.
module imu_complementary_tilt_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ctf_sample_if.sink          i_sample,
    ctf_result_if.source        o_result,
    input  logic                i_cfg_we,
    input  logic         [2:0]  i_cfg_idx,
    input  logic         [15:0] i_cfg_data
);
    ctf_pkg::t_top_state r_state, n_state;

    // Configuration registers.
    logic        [10:0] r_gyro_weight;
    logic signed [12:0] r_roll_trim;
    logic signed [12:0] r_pitch_trim;
    logic signed [15:0] r_gyro_offset_x;
    logic signed [15:0] r_gyro_offset_y;
    logic signed [15:0] r_gyro_offset_z;

    // Filter state, also the result payload.
    logic signed [16:0] r_roll;
    logic signed [16:0] r_pitch;
    logic signed [16:0] r_yaw;
    logic               r_out_valid;

    // Yaw reduction.
    logic        [24:0] r_yt;
    logic        [2:0]  r_wk;
    logic               r_wbusy;

    logic               w_accept;
    logic               w_front_done;
    logic               w_back_start;
    logic               w_load;
    logic signed [16:0] w_roll_num;
    logic signed [16:0] w_pitch_num;
    logic signed [16:0] w_rate_x;
    logic signed [16:0] w_rate_y;
    logic signed [16:0] w_rate_z;
    logic signed [16:0] w_tilt_roll;
    logic signed [16:0] w_tilt_pitch;
    logic               w_tilt_roll_done;
    logic               w_tilt_pitch_done;
    logic signed [24:0] w_incr_x;
    logic signed [24:0] w_incr_y;
    logic signed [24:0] w_incr_z;
    logic               w_gyro_x_done;
    logic               w_gyro_y_done;
    logic               w_gyro_z_done;
    logic signed [17:0] w_acc_roll;
    logic signed [17:0] w_acc_pitch;
    logic signed [16:0] w_blend_roll;
    logic signed [16:0] w_blend_pitch;
    logic               w_blend_roll_done;
    logic               w_blend_pitch_done;
    logic        [26:0] w_yaw_t;
    logic        [24:0] w_span_sh;
    logic        [17:0] w_yaw_fin;

    assign w_accept = i_sample.valid && i_sample.ready;

    // Numerators and bias-corrected rates of the sample.
    assign w_roll_num  = {i_sample.accel_y[15], i_sample.accel_y};
    assign w_pitch_num = -{i_sample.accel_x[15], i_sample.accel_x};
    assign w_rate_x = {i_sample.gyro_x[15], i_sample.gyro_x} -
                      {r_gyro_offset_x[15], r_gyro_offset_x};
    assign w_rate_y = {i_sample.gyro_y[15], i_sample.gyro_y} -
                      {r_gyro_offset_y[15], r_gyro_offset_y};
    assign w_rate_z = {i_sample.gyro_z[15], i_sample.gyro_z} -
                      {r_gyro_offset_z[15], r_gyro_offset_z};

    // Accelerometer tilt units.
    ctf_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_tilt_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_num   (w_roll_num),
        .i_a     (i_sample.accel_x),
        .i_b     (i_sample.accel_z),
        .o_angle (w_tilt_roll),
        .o_done  (w_tilt_roll_done)
    );

    ctf_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_tilt_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_num   (w_pitch_num),
        .i_a     (i_sample.accel_y),
        .i_b     (i_sample.accel_z),
        .o_angle (w_tilt_pitch),
        .o_done  (w_tilt_pitch_done)
    );

    // Gyro increment units, one per axis.
    ctf_gyro u_gyro_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_rate  (w_rate_x),
        .i_ms    (i_sample.elapsed_ms),
        .o_incr  (w_incr_x),
        .o_done  (w_gyro_x_done)
    );

    ctf_gyro u_gyro_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_rate  (w_rate_y),
        .i_ms    (i_sample.elapsed_ms),
        .o_incr  (w_incr_y),
        .o_done  (w_gyro_y_done)
    );

    ctf_gyro u_gyro_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_rate  (w_rate_z),
        .i_ms    (i_sample.elapsed_ms),
        .o_incr  (w_incr_z),
        .o_done  (w_gyro_z_done)
    );

    assign w_front_done = w_tilt_roll_done && w_tilt_pitch_done &&
                          w_gyro_x_done && w_gyro_y_done && w_gyro_z_done;

    // Trimmed accelerometer angles.
    assign w_acc_roll  = {w_tilt_roll[16], w_tilt_roll} +
                         {{5{r_roll_trim[12]}}, r_roll_trim};
    assign w_acc_pitch = {w_tilt_pitch[16], w_tilt_pitch} +
                         {{5{r_pitch_trim[12]}}, r_pitch_trim};

    // Blend units.
    ctf_blend u_blend_roll (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_back_start),
        .i_weight (r_gyro_weight),
        .i_prev   (r_roll),
        .i_incr   (w_incr_x),
        .i_accel  (w_acc_roll),
        .o_angle  (w_blend_roll),
        .o_done   (w_blend_roll_done)
    );

    ctf_blend u_blend_pitch (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_back_start),
        .i_weight (r_gyro_weight),
        .i_prev   (r_pitch),
        .i_incr   (w_incr_y),
        .i_accel  (w_acc_pitch),
        .o_angle  (w_blend_pitch),
        .o_done   (w_blend_pitch_done)
    );

    // Yaw sum, biased by half a turn plus whole turns so that it is always positive.
    assign w_yaw_t   = {{10{r_yaw[16]}}, r_yaw} + {{2{w_incr_z[24]}}, w_incr_z} +
                       27'(ctf_pkg::YAW_BIAS);
    assign w_span_sh = 25'(ctf_pkg::ANG_SPAN) << r_wk;
    assign w_yaw_fin = {1'b0, r_yt[16:0]} - 18'(ctf_pkg::ANG_LIMIT);

    // Next state and handshake controls.
    always_comb begin
        n_state      = r_state;
        w_back_start = 1'b0;
        w_load       = 1'b0;
        case (r_state)
            ctf_pkg::S_IDLE: begin
                if (w_accept) n_state = ctf_pkg::S_FRONT;
            end
            ctf_pkg::S_FRONT: begin
                if (w_front_done) begin
                    w_back_start = 1'b1;
                    n_state      = ctf_pkg::S_BACK;
                end
            end
            ctf_pkg::S_BACK: begin
                if (w_blend_roll_done && w_blend_pitch_done && !r_wbusy) begin
                    n_state = ctf_pkg::S_DONE;
                end
            end
            ctf_pkg::S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    w_load  = 1'b1;
                    n_state = ctf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ctf_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers, configuration and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ctf_pkg::S_IDLE;
            r_out_valid     <= 1'b0;
            r_wbusy         <= 1'b0;
            r_gyro_weight   <= 11'd983;
            r_roll_trim     <= -13'sd148;
            r_pitch_trim    <= 13'sd404;
            r_gyro_offset_x <= '0;
            r_gyro_offset_y <= '0;
            r_gyro_offset_z <= '0;
            r_roll          <= '0;
            r_pitch         <= '0;
            r_yaw           <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ctf_pkg::CFG_GYRO_WEIGHT:   r_gyro_weight   <= i_cfg_data[10:0];
                    ctf_pkg::CFG_ROLL_TRIM:     r_roll_trim     <= i_cfg_data[12:0];
                    ctf_pkg::CFG_PITCH_TRIM:    r_pitch_trim    <= i_cfg_data[12:0];
                    ctf_pkg::CFG_GYRO_OFFSET_X: r_gyro_offset_x <= i_cfg_data;
                    ctf_pkg::CFG_GYRO_OFFSET_Y: r_gyro_offset_y <= i_cfg_data;
                    ctf_pkg::CFG_GYRO_OFFSET_Z: r_gyro_offset_z <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // Yaw reduction runs one turn multiple per cycle.
            if (w_back_start) begin
                r_wbusy <= 1'b1;
            end else if (r_wbusy && r_wk == 3'd0) begin
                r_wbusy <= 1'b0;
            end

            if (w_load) begin
                r_roll      <= w_blend_roll;
                r_pitch     <= w_blend_pitch;
                r_yaw       <= w_yaw_fin[16:0];
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Yaw reduction datapath.
    always_ff @(posedge i_clk) begin
        if (w_back_start) begin
            r_yt <= w_yaw_t[24:0];
            r_wk <= 3'(ctf_pkg::YAW_WRAP_STEPS - 1);
        end else if (r_wbusy) begin
            if (r_yt >= w_span_sh) r_yt <= r_yt - w_span_sh;
            r_wk <= r_wk - 3'd1;
        end
    end

    assign i_sample.ready     = (r_state == ctf_pkg::S_IDLE);
    assign o_result.valid     = r_out_valid;
    assign o_result.roll_out  = r_roll;
    assign o_result.pitch_out = r_pitch;
    assign o_result.yaw_out   = r_yaw;

    // The blend only starts once every front unit has finished.
    a_front_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ctf_pkg::S_BACK |-> w_front_done)
        else $error("top: back end running before front units finished");

    // A result beat only appears from the final state.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ctf_pkg::S_DONE)
        else $error("top: result valid raised outside the final state");

    // The yaw reduction leaves less than one turn.
    a_yaw_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ctf_pkg::S_DONE |-> r_yt < 25'(ctf_pkg::ANG_SPAN))
        else $error("top: yaw not reduced below one turn");

    // The yaw output stays inside its wrapped range.
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_yaw >= 17'(-ctf_pkg::ANG_LIMIT) &&
                        r_yaw <= 17'(ctf_pkg::ANG_LIMIT - 1))
        else $error("top: yaw output out of range");

endmodule

// ----- src/ctf_tilt.sv -----
// ============================================================================
// ctf_tilt
// Accelerometer tilt angle: bit-serial square root of a^2 + b^2 followed by
// a one-step-per-cycle CORDIC vectoring pass.
// ============================================================================
module ctf_tilt #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_num,
    input  logic signed [15:0] i_a,
    input  logic signed [15:0] i_b,
    output logic signed [16:0] o_angle,
    output logic               o_done
);
    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    ctf_pkg::t_tilt_state r_state, n_state;

    logic        [4:0]    r_cnt;
    logic        [15:0]   r_bmag;
    logic        [31:0]   r_sq;
    logic        [47:0]   r_rad;
    logic        [25:0]   r_rem;
    logic        [23:0]   r_root;
    logic signed [16:0]   r_num;
    logic signed [26:0]   r_x;
    logic signed [26:0]   r_y;
    logic signed [24:0]   r_z;
    logic        [IW-1:0] r_i;
    logic signed [16:0]   r_angle;
    logic                 r_done;

    logic        [15:0] w_amag;
    logic        [15:0] w_bmag;
    logic        [27:0] w_rem_sh;
    logic        [27:0] w_trial;
    logic        [27:0] w_rem_sub;
    logic               w_fit;
    logic        [23:0] w_root_nx;
    logic signed [26:0] w_xs;
    logic signed [26:0] w_ys;
    logic signed [26:0] w_x_nx;
    logic signed [26:0] w_y_nx;
    logic signed [24:0] w_z_nx;
    logic signed [24:0] w_z_rnd;
    logic               w_last_root;
    logic               w_last_rot;
    logic               w_zero;

    // Operand magnitudes.
    assign w_amag = i_a[15] ? 16'(-i_a) : 16'(i_a);
    assign w_bmag = i_b[15] ? 16'(-i_b) : 16'(i_b);

    // One root digit per cycle, two radicand bits consumed.
    assign w_rem_sh    = {r_rem, r_rad[47:46]};
    assign w_trial     = {2'b00, r_root, 2'b01};
    assign w_fit       = (w_rem_sh >= w_trial);
    assign w_rem_sub   = w_rem_sh - w_trial;
    assign w_root_nx   = {r_root[22:0], w_fit};
    assign w_last_root = (r_cnt == 5'(ctf_pkg::ROOT_STEPS - 1));
    assign w_zero      = (w_root_nx == 24'd0) && (r_num == 17'sd0);

    // One CORDIC rotation per cycle, driving y toward zero.
    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    always_comb begin
        if (!r_y[26]) begin
            w_x_nx = r_x + w_ys;
            w_y_nx = r_y - w_xs;
            w_z_nx = r_z + ctf_pkg::atan_step(5'(r_i));
        end else begin
            w_x_nx = r_x - w_ys;
            w_y_nx = r_y + w_xs;
            w_z_nx = r_z - ctf_pkg::atan_step(5'(r_i));
        end
    end
    assign w_z_rnd    = w_z_nx + 25'sd128;
    assign w_last_rot = (r_i == IW'(CORDIC_STEPS - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ctf_pkg::T_IDLE: begin
                if (i_start) n_state = ctf_pkg::T_SQB;
            end
            ctf_pkg::T_SQB: begin
                n_state = ctf_pkg::T_ROOT;
            end
            ctf_pkg::T_ROOT: begin
                if (w_last_root) n_state = w_zero ? ctf_pkg::T_IDLE : ctf_pkg::T_ROT;
            end
            ctf_pkg::T_ROT: begin
                if (w_last_rot) n_state = ctf_pkg::T_IDLE;
            end
            default: begin
                n_state = ctf_pkg::T_IDLE;
            end
        endcase
    end

    // State and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctf_pkg::T_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_start) begin
                r_done <= 1'b0;
            end else if ((r_state == ctf_pkg::T_ROOT && w_last_root && w_zero) ||
                         (r_state == ctf_pkg::T_ROT && w_last_rot)) begin
                r_done <= 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ctf_pkg::T_IDLE: begin
                if (i_start) begin
                    r_sq   <= {16'd0, w_amag} * {16'd0, w_amag};
                    r_bmag <= w_bmag;
                    r_num  <= i_num;
                end
            end
            ctf_pkg::T_SQB: begin
                r_rad  <= {r_sq + {16'd0, r_bmag} * {16'd0, r_bmag}, 16'd0};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            ctf_pkg::T_ROOT: begin
                r_rem  <= w_fit ? w_rem_sub[25:0] : w_rem_sh[25:0];
                r_root <= w_root_nx;
                r_rad  <= {r_rad[45:0], 2'b00};
                r_cnt  <= r_cnt + 5'd1;
                if (w_last_root) begin
                    r_x <= {3'b000, w_root_nx};
                    r_y <= {{2{r_num[16]}}, r_num, 8'd0};
                    r_z <= '0;
                    r_i <= '0;
                    if (w_zero) r_angle <= '0;
                end
            end
            ctf_pkg::T_ROT: begin
                r_x <= w_x_nx;
                r_y <= w_y_nx;
                r_z <= w_z_nx;
                r_i <= r_i + IW'(1);
                if (w_last_rot) r_angle <= w_z_rnd[24:8];
            end
            default: begin
            end
        endcase
    end

    assign o_angle = r_angle;
    assign o_done  = r_done;

    // The square root remainder never exceeds twice the root.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ctf_pkg::T_ROT |-> r_rem <= {1'b0, r_root, 1'b0})
        else $error("tilt: square root remainder out of bound");

    // Completion is only flagged as the rotation or the zero case ends.
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_state) == ctf_pkg::T_ROT ||
                          $past(r_state) == ctf_pkg::T_ROOT)
        else $error("tilt: done raised outside the iteration");

    // A new start always clears a previous completion.
    a_start_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> !r_done)
        else $error("tilt: done survived a start");

endmodule

// ----- src/ctf_gyro.sv -----
// ============================================================================
// ctf_gyro
// Gyro angle increment: bit-serial rate * ms product, then a restoring
// division by a constant, one quotient bit per cycle, rounded to nearest.
// ============================================================================
module ctf_gyro (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_rate,
    input  logic        [15:0] i_ms,
    output logic signed [24:0] o_incr,
    output logic               o_done
);
    ctf_pkg::t_gyro_state r_state, n_state;

    logic        [4:0]  r_cnt;
    logic        [15:0] r_mag;
    logic               r_neg;
    logic        [15:0] r_ms;
    logic        [31:0] r_prod;
    logic        [14:0] r_rem;
    logic        [24:0] r_dlo;
    logic        [24:0] r_q;
    logic signed [24:0] r_incr;
    logic               r_done;

    logic [16:0] w_mag;
    logic [38:0] w_div;
    logic [15:0] w_sh;
    logic [15:0] w_sub;
    logic        w_ge;
    logic [24:0] w_q_nx;
    logic        w_last_mul;
    logic        w_last_div;

    assign w_mag = i_rate[16] ? 17'(-i_rate) : 17'(i_rate);

    // Rounded dividend: rate * ms * 64 plus half the divisor.
    assign w_div = {1'b0, r_prod, 6'd0} + 39'(ctf_pkg::GYRO_ROUND);

    // Restoring division step.
    assign w_sh   = {r_rem, r_dlo[24]};
    assign w_ge   = (w_sh >= 16'(ctf_pkg::GYRO_DIV));
    assign w_sub  = w_sh - 16'(ctf_pkg::GYRO_DIV);
    assign w_q_nx = {r_q[23:0], w_ge};

    assign w_last_mul = (r_cnt == 5'(ctf_pkg::MUL_STEPS - 1));
    assign w_last_div = (r_cnt == 5'(ctf_pkg::DIV_STEPS - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ctf_pkg::G_IDLE: begin
                if (i_start) n_state = ctf_pkg::G_MUL;
            end
            ctf_pkg::G_MUL: begin
                if (w_last_mul) n_state = ctf_pkg::G_LOAD;
            end
            ctf_pkg::G_LOAD: begin
                n_state = ctf_pkg::G_DIV;
            end
            ctf_pkg::G_DIV: begin
                if (w_last_div) n_state = ctf_pkg::G_IDLE;
            end
            default: begin
                n_state = ctf_pkg::G_IDLE;
            end
        endcase
    end

    // State and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctf_pkg::G_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_start) begin
                r_done <= 1'b0;
            end else if (r_state == ctf_pkg::G_DIV && w_last_div) begin
                r_done <= 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ctf_pkg::G_IDLE: begin
                if (i_start) begin
                    r_mag  <= w_mag[15:0];
                    r_neg  <= i_rate[16];
                    r_ms   <= i_ms;
                    r_prod <= '0;
                    r_cnt  <= '0;
                end
            end
            ctf_pkg::G_MUL: begin
                r_prod <= {r_prod[30:0], 1'b0} + (r_ms[15] ? {16'd0, r_mag} : 32'd0);
                r_ms   <= {r_ms[14:0], 1'b0};
                r_cnt  <= r_cnt + 5'd1;
            end
            ctf_pkg::G_LOAD: begin
                // The top 14 bits are below the divisor, so no quotient bit there.
                r_rem <= {1'b0, w_div[38:25]};
                r_dlo <= w_div[24:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            ctf_pkg::G_DIV: begin
                r_rem <= w_ge ? w_sub[14:0] : w_sh[14:0];
                r_dlo <= {r_dlo[23:0], 1'b0};
                r_q   <= w_q_nx;
                r_cnt <= r_cnt + 5'd1;
                if (w_last_div) r_incr <= r_neg ? -w_q_nx : w_q_nx;
            end
            default: begin
            end
        endcase
    end

    assign o_incr = r_incr;
    assign o_done = r_done;

    // The partial remainder always stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ctf_pkg::G_DIV |-> {1'b0, r_rem} < 16'(ctf_pkg::GYRO_DIV))
        else $error("gyro: division remainder out of bound");

    // Completion is only flagged by the last division step.
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_state) == ctf_pkg::G_DIV)
        else $error("gyro: done raised outside the division");

    // The quotient never reaches the top bit, so the sign flip cannot overflow.
    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ctf_pkg::G_DIV |-> !r_q[24])
        else $error("gyro: quotient overflow");

endmodule

// ----- src/ctf_blend.sv -----
// ============================================================================
// ctf_blend
// Complementary blend w*(prev + incr) + (1 - w)*accel with a bit-serial
// multiply-accumulate over the weight bits, then rounding and saturation.
// ============================================================================
module ctf_blend (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic        [10:0] i_weight,
    input  logic signed [16:0] i_prev,
    input  logic signed [24:0] i_incr,
    input  logic signed [17:0] i_accel,
    output logic signed [16:0] o_angle,
    output logic               o_done
);
    ctf_pkg::t_blend_state r_state, n_state;

    logic        [3:0]  r_cnt;
    logic signed [25:0] r_a;
    logic signed [17:0] r_b;
    logic        [10:0] r_wg;
    logic        [10:0] r_wa;
    logic signed [37:0] r_s;
    logic signed [16:0] r_angle;
    logic               r_done;

    logic        [10:0] w_wc;
    logic signed [37:0] w_pa;
    logic signed [37:0] w_pb;
    logic signed [37:0] w_rnd;
    logic signed [27:0] w_r;
    logic signed [16:0] w_sat;
    logic               w_last;

    // A weight above one acts as one.
    assign w_wc = (i_weight > 11'(ctf_pkg::WEIGHT_ONE)) ? 11'(ctf_pkg::WEIGHT_ONE) : i_weight;

    // Partial products of the current weight bits, MSB first.
    assign w_pa   = r_wg[10] ? {{12{r_a[25]}}, r_a} : 38'sd0;
    assign w_pb   = r_wa[10] ? {{20{r_b[17]}}, r_b} : 38'sd0;
    assign w_last = (r_cnt == 4'(ctf_pkg::BLEND_STEPS - 1));

    // Round to nearest in Q10 and clamp to half a turn.
    assign w_rnd = r_s + 38'sd512;
    assign w_r   = w_rnd[37:10];
    always_comb begin
        if (w_r > 28'(ctf_pkg::ANG_LIMIT)) begin
            w_sat = 17'(ctf_pkg::ANG_LIMIT);
        end else if (w_r < 28'(-ctf_pkg::ANG_LIMIT)) begin
            w_sat = 17'(-ctf_pkg::ANG_LIMIT);
        end else begin
            w_sat = w_r[16:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ctf_pkg::B_IDLE: begin
                if (i_start) n_state = ctf_pkg::B_MAC;
            end
            ctf_pkg::B_MAC: begin
                if (w_last) n_state = ctf_pkg::B_FIN;
            end
            ctf_pkg::B_FIN: begin
                n_state = ctf_pkg::B_IDLE;
            end
            default: begin
                n_state = ctf_pkg::B_IDLE;
            end
        endcase
    end

    // State and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctf_pkg::B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_start) begin
                r_done <= 1'b0;
            end else if (r_state == ctf_pkg::B_FIN) begin
                r_done <= 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ctf_pkg::B_IDLE: begin
                if (i_start) begin
                    r_a   <= {{9{i_prev[16]}}, i_prev} + {i_incr[24], i_incr};
                    r_b   <= i_accel;
                    r_wg  <= w_wc;
                    r_wa  <= 11'(ctf_pkg::WEIGHT_ONE) - w_wc;
                    r_s   <= '0;
                    r_cnt <= '0;
                end
            end
            ctf_pkg::B_MAC: begin
                r_s   <= {r_s[36:0], 1'b0} + w_pa + w_pb;
                r_wg  <= {r_wg[9:0], 1'b0};
                r_wa  <= {r_wa[9:0], 1'b0};
                r_cnt <= r_cnt + 4'd1;
            end
            ctf_pkg::B_FIN: begin
                r_angle <= w_sat;
            end
            default: begin
            end
        endcase
    end

    assign o_angle = r_angle;
    assign o_done  = r_done;

    // The two weights always sum to one.
    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ctf_pkg::B_MAC) |-> 12'(r_wg) + 12'(r_wa) ==
                                             12'(ctf_pkg::WEIGHT_ONE))
        else $error("blend: weights do not sum to one");

    // The finished angle stays inside half a turn.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> r_angle <= 17'(ctf_pkg::ANG_LIMIT) &&
                          r_angle >= 17'(-ctf_pkg::ANG_LIMIT))
        else $error("blend: angle outside saturation range");

    // Completion follows the final rounding step.
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_state) == ctf_pkg::B_FIN)
        else $error("blend: done raised outside the final step");

endmodule

// ----- tb/ctf_tb_pkg.sv -----
// ============================================================================
// ctf_tb_pkg
// Angle predictor and result scoreboard for the tilt filter testbench.
// ============================================================================
package ctf_tb_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    // One expected or observed angle triple.
    typedef struct {
        logic signed [16:0] roll;
        logic signed [16:0] pitch;
        logic signed [16:0] yaw;
    } t_angles;

    // One IMU sample as driven on the input channel.
    typedef struct {
        logic signed [15:0] ax, ay, az, gx, gy, gz;
        logic [15:0]        ms;
    } t_sample;

    class tilt_scoreboard;
        // Register copies and filter state.
        logic [10:0]        weight;
        logic signed [12:0] roll_trim, pitch_trim;
        logic signed [15:0] off_x, off_y, off_z;
        longint             roll_st, pitch_st, yaw_st;
        int                 cordic_steps;
        t_angles            pending[$];
        int                 errors;

        function new(int steps);
            cordic_steps = steps;
            errors = 0;
            weight = 11'd983;
            roll_trim = -13'sd148;
            pitch_trim = 13'sd404;
            off_x = '0;
            off_y = '0;
            off_z = '0;
            roll_st = 0;
            pitch_st = 0;
            yaw_st = 0;
        endfunction

        function void write_reg(ctf_pkg::t_cfg_idx idx, logic [15:0] data);
            case (idx)
                ctf_pkg::CFG_GYRO_WEIGHT:   weight = data[10:0];
                ctf_pkg::CFG_ROLL_TRIM:     roll_trim = data[12:0];
                ctf_pkg::CFG_PITCH_TRIM:    pitch_trim = data[12:0];
                ctf_pkg::CFG_GYRO_OFFSET_X: off_x = data;
                ctf_pkg::CFG_GYRO_OFFSET_Y: off_y = data;
                ctf_pkg::CFG_GYRO_OFFSET_Z: off_z = data;
                default: ;
            endcase
        endfunction

        static function longint int_sqrt(longint unsigned n);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        // Accelerometer tilt: atan(num / sqrt(a^2 + b^2)) in 1/256 degree.
        function longint accel_tilt(longint num, longint a, longint b);
            longint x, y, z, xs, ys;
            x = int_sqrt(longint'(a * a + b * b) << 16);
            y = num * 256;
            z = 0;
            if (x == 0 && y == 0) return 0;
            for (int i = 0; i < cordic_steps && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x += ys;
                    y -= xs;
                    z += longint'(ctf_pkg::atan_step(i[4:0]));
                end else begin
                    x -= ys;
                    y += xs;
                    z -= longint'(ctf_pkg::atan_step(i[4:0]));
                end
            end
            return (z + 128) >>> 8;
        endfunction

        // Rate times interval, rounded half away from zero.
        static function longint rate_step(longint rate, longint ms);
            longint p, q;
            p = rate * ms * 32;
            q = ((p < 0 ? -p : p) * 2 + 16375) / 32750;
            return p < 0 ? -q : q;
        endfunction

        function longint mix(longint prev, longint incr, longint acc);
            longint w, r;
            w = (weight > 1024) ? 1024 : weight;
            r = (w * (prev + incr) + (1024 - w) * acc + 512) >>> 10;
            if (r > ctf_pkg::ANG_LIMIT) r = ctf_pkg::ANG_LIMIT;
            if (r < -ctf_pkg::ANG_LIMIT) r = -ctf_pkg::ANG_LIMIT;
            return r;
        endfunction

        // Works out the angles that an accepted sample must produce.
        function void note_sample(t_sample s);
            longint acc_r, acc_p, r;
            t_angles e;
            acc_r = accel_tilt(s.ay, s.ax, s.az) + longint'(roll_trim);
            acc_p = accel_tilt(-longint'(s.ax), s.ay, s.az) + longint'(pitch_trim);
            roll_st = mix(roll_st, rate_step(longint'(s.gx) - longint'(off_x),
                                             longint'(s.ms)), acc_r);
            pitch_st = mix(pitch_st, rate_step(longint'(s.gy) - longint'(off_y),
                                               longint'(s.ms)), acc_p);
            r = (yaw_st + rate_step(longint'(s.gz) - longint'(off_z), longint'(s.ms)) +
                 ctf_pkg::ANG_LIMIT) % ctf_pkg::ANG_SPAN;
            if (r < 0) r += ctf_pkg::ANG_SPAN;
            yaw_st = r - ctf_pkg::ANG_LIMIT;
            e.roll = roll_st[16:0];
            e.pitch = pitch_st[16:0];
            e.yaw = yaw_st[16:0];
            pending.push_back(e);
        endfunction

        function void check_result(t_angles got);
            t_angles e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d",
                         $time, got.roll, got.pitch, got.yaw);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.roll !== e.roll) begin
                $display("%0t: roll expected %0d actual %0d", $time, e.roll, got.roll);
                errors++;
            end
            if (got.pitch !== e.pitch) begin
                $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, got.pitch);
                errors++;
            end
            if (got.yaw !== e.yaw) begin
                $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, got.yaw);
                errors++;
            end
        endfunction
    endclass

endpackage

// ----- tb/tb_imu_complementary_tilt_filter.sv -----
// ============================================================================
// tb_imu_complementary_tilt_filter
// Drives IMU samples and register settings into the tilt filter with random
// idling and back-pressure, and checks every angle beat against a predictor.
// ============================================================================
module tb_imu_complementary_tilt_filter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS      = 16;
    localparam int LATENCY    = 80;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    ctf_sample_if i_sample();
    ctf_result_if o_result();

    ctf_tb_pkg::tilt_scoreboard sb;
    bit             hold_off;     // long receiver stall requested
    bit             rx_random;    // receiver stalls at random
    bit             tx_random;    // sender gaps at random
    bit             stim_done;
    int             idle_cycles;

    imu_complementary_tilt_filter #(.CORDIC_STEPS(STEPS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (i_sample),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stall per beat, plus a long hold-off when requested.
    initial begin
        int wait_n;
        o_result.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            wait_n = rx_random ? $urandom_range(0, 17) : 0;
            if ($urandom_range(0, 3) == 0) wait_n = 0;
            while (hold_off || wait_n > 0) begin
                o_result.ready <= 1'b0;
                if (wait_n > 0) wait_n--;
                @(posedge i_clk);
            end
            o_result.ready <= 1'b1;
            @(posedge i_clk);
            while (!o_result.valid) @(posedge i_clk);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        ctf_tb_pkg::t_angles got;
        if (i_rst_n && o_result.valid && o_result.ready) begin
            got.roll = o_result.roll_out;
            got.pitch = o_result.pitch_out;
            got.yaw = o_result.yaw_out;
            sb.check_result(got);
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((i_sample.valid && i_sample.ready) || (o_result.valid && o_result.ready)
            || !i_rst_n || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(ctf_pkg::t_cfg_idx idx, logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Sends one sample beat, after a random gap when enabled.
    task automatic send_sample(ctf_tb_pkg::t_sample s);
        int gap;
        gap = tx_random ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_sample.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sample.valid <= 1'b1;
        i_sample.accel_x <= s.ax;
        i_sample.accel_y <= s.ay;
        i_sample.accel_z <= s.az;
        i_sample.gyro_x <= s.gx;
        i_sample.gyro_y <= s.gy;
        i_sample.gyro_z <= s.gz;
        i_sample.elapsed_ms <= s.ms;
        @(posedge i_clk);
        while (!i_sample.ready) @(posedge i_clk);
        sb.note_sample(s);
    endtask

    task automatic release_sample();
        i_sample.valid <= 1'b0;
    endtask

    // Waits until every expected result has come, then lets the block settle.
    task automatic drain();
        release_sample();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic ctf_tb_pkg::t_sample make_sample(int kind);
        ctf_tb_pkg::t_sample s;
        s.ax = 16'($urandom);
        s.ay = 16'($urandom);
        s.az = 16'($urandom);
        s.gx = 16'($urandom);
        s.gy = 16'($urandom);
        s.gz = 16'($urandom);
        s.ms = 16'($urandom);
        case (kind)
            // Realistic: about 1 g, moderate rates, short intervals.
            0, 1, 2: begin
                s.ax = $signed(16'($urandom_range(0, 20000))) - 16'sd10000;
                s.ay = $signed(16'($urandom_range(0, 20000))) - 16'sd10000;
                s.az = 16'sd16384 - $signed(16'($urandom_range(0, 8000)));
                s.gx = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
                s.gy = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
                s.gz = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
                s.ms = 16'($urandom_range(0, 50));
            end
            // Full-range fields with short intervals.
            3: s.ms = 16'($urandom_range(0, 255));
            default: ;
        endcase
        return s;
    endfunction

    initial begin
        ctf_tb_pkg::t_sample s;
        ctf_tb_pkg::t_sample d[$];
        logic signed [15:0] ext[4];
        sb = new(STEPS);
        hold_off = 1'b0;
        rx_random = 1'b0;
        tx_random = 1'b0;
        stim_done = 1'b0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = ctf_pkg::CFG_GYRO_WEIGHT;
        i_cfg_data = '0;
        i_sample.valid = 1'b0;
        i_sample.accel_x = '0;
        i_sample.accel_y = '0;
        i_sample.accel_z = '0;
        i_sample.gyro_x = '0;
        i_sample.gyro_y = '0;
        i_sample.gyro_z = '0;
        i_sample.elapsed_ms = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed samples at reset settings: zero vector, extremes, long interval.
        ext = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1};
        d.push_back('{0, 0, 0, 0, 0, 0, 0});
        d.push_back('{0, 0, 0, 0, 0, 0, 16'hffff});
        d.push_back('{0, 0, 16'sd16384, 16'sd131, -16'sd131, 16'sd131, 16'd10});
        foreach (ext[i]) begin
            foreach (ext[j]) begin
                s = '{ext[i], ext[j], ext[(i + j) % 4], ext[j], ext[i], ext[(i + 1) % 4],
                      (i == j) ? 16'hffff : 16'd1000};
                d.push_back(s);
            end
        end
        d.push_back('{16'sh7fff, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff});
        d.push_back('{16'sh8000, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'hffff});
        foreach (d[i]) send_sample(d[i]);
        drain();

        // Register extremes: weight above one, trims and offsets at their limits.
        write_reg(ctf_pkg::CFG_GYRO_WEIGHT, 16'd2047);
        write_reg(ctf_pkg::CFG_ROLL_TRIM, 16'h1000);
        write_reg(ctf_pkg::CFG_PITCH_TRIM, 16'h0fff);
        write_reg(ctf_pkg::CFG_GYRO_OFFSET_X, 16'h8000);
        write_reg(ctf_pkg::CFG_GYRO_OFFSET_Y, 16'h7fff);
        write_reg(ctf_pkg::CFG_GYRO_OFFSET_Z, 16'hffff);
        foreach (d[i]) if (i < 6) send_sample(d[i]);
        drain();

        // Random phases, each with its own register setting.
        rx_random = 1'b1;
        tx_random = 1'b1;
        for (int ph = 0; ph < 9; ph++) begin
            case (ph % 3)
                0: write_reg(ctf_pkg::CFG_GYRO_WEIGHT, 16'(ph == 0 ? 0 : 1024));
                1: write_reg(ctf_pkg::CFG_GYRO_WEIGHT, 16'($urandom_range(0, 2047)));
                default: write_reg(ctf_pkg::CFG_GYRO_WEIGHT, 16'd983);
            endcase
            write_reg(ctf_pkg::CFG_ROLL_TRIM, 16'($urandom_range(0, 5120)) - 16'd2560);
            write_reg(ctf_pkg::CFG_PITCH_TRIM, 16'($urandom));
            write_reg(ctf_pkg::CFG_GYRO_OFFSET_X, 16'($urandom_range(0, 200)) - 16'd100);
            write_reg(ctf_pkg::CFG_GYRO_OFFSET_Y, 16'($urandom));
            write_reg(ctf_pkg::CFG_GYRO_OFFSET_Z, 16'($urandom_range(0, 200)) - 16'd100);
            if (ph == 4) begin
                // Long receiver hold-off while the sender keeps offering beats.
                tx_random = 1'b0;
                hold_off = 1'b1;
                fork
                    begin
                        repeat (600) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                    for (int k = 0; k < 150; k++) send_sample(make_sample($urandom_range(0, 4)));
                join
                tx_random = 1'b1;
            end else begin
                for (int k = 0; k < 150; k++) send_sample(make_sample($urandom_range(0, 4)));
            end
            drain();
        end

        stim_done = 1'b1;
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
